>>> rtl/sdsi_pkg.sv
// ----------------------------------------------------------------------------
// sdsi_pkg
// Types and constants shared by the sorted insert table files.
// ----------------------------------------------------------------------------
package sdsi_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 7;
  localparam int unsigned NAME_W   = 64;
  localparam int unsigned REC_W    = KEY_W + 2 * NAME_W;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_DRAIN  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_IGNORED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_ENTRY    = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [NAME_W-1:0] name_high;
    logic [NAME_W-1:0] name_low;
  } rec_t;

  typedef struct packed {
    status_e           status;
    logic [KEY_W-1:0]  key;
    logic [NAME_W-1:0] name_high;
    logic [NAME_W-1:0] name_low;
    logic              group_start;
    logic              last;
  } res_t;

endpackage

>>> rtl/sdsi_in_if.sv
// ----------------------------------------------------------------------------
// sdsi_in_if
// Command channel: insert or drain items with a record payload.
// ----------------------------------------------------------------------------
interface sdsi_in_if;
  import sdsi_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [7:0]        rank_key;
  logic [NAME_W-1:0] name_high;
  logic [NAME_W-1:0] name_low;

  modport source (output valid, cmd, rank_key, name_high, name_low, input ready);
  modport sink   (input valid, cmd, rank_key, name_high, name_low, output ready);
endinterface

>>> rtl/sdsi_out_if.sv
// ----------------------------------------------------------------------------
// sdsi_out_if
// Result channel: status items and emitted table entries.
// ----------------------------------------------------------------------------
interface sdsi_out_if;
  import sdsi_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [KEY_W-1:0]  out_key;
  logic [NAME_W-1:0] out_name_high;
  logic [NAME_W-1:0] out_name_low;
  logic              group_start;
  logic              last;

  modport source (output valid, status, out_key, out_name_high, out_name_low,
                  group_start, last, input ready);
  modport sink   (input valid, status, out_key, out_name_high, out_name_low,
                  group_start, last, output ready);
endinterface

>>> rtl/sdsi_ram.sv
// ----------------------------------------------------------------------------
// sdsi_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sdsi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/stable_descending_sorted_insert.sv
// ----------------------------------------------------------------------------
// stable_descending_sorted_insert
// Table of records kept in descending key order, stable on equal keys.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries insert and drain items; out_o carries results. Both are
//   valid/ready channels, an item moves on an edge with valid and ready high.
//   An insert gives one result: inserted, ignored (key zero or below) or
//   full. Ignored and full pass through S_RESP to the output register.
//   An insert into a table of n entries scans the record RAM from the
//   bottom, moving one entry down per cycle, as the RAM has a single read
//   port and a single write port. A drain emits all entries in order,
//   one per cycle while the output register is free, each from a
//   registered RAM read, then empties the table; an empty table answers
//   one empty status item. Input ready is high only between items.
//   The output register holds a result while out_o.ready is low; the block
//   then waits and loses nothing. Reset clears the entry count and the
//   control state; RAM contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module stable_descending_sorted_insert (
  input  logic  clk_i,
  input  logic  rst_ni,
  sdsi_in_if.sink    in_i,
  sdsi_out_if.source out_o
);
  import sdsi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_INS_SCAN = 5'b00010,
    S_INS_PUT  = 5'b00100,
    S_DRN_RD   = 5'b01000,
    S_RESP     = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  rec_t             new_q, new_d;
  status_e          pend_q, pend_d;
  logic             first_q, first_d;
  logic [KEY_W-1:0] prev_q, prev_d;
  logic             out_valid_q;
  res_t             out_q, res_d;
  logic             out_free, out_load;

  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  rec_t             mem_wdata, mem_rdata;
  logic [REC_W-1:0] mem_rdata_raw;
  logic [IDX_W:0]   idx_inc;
  logic             accept, drain_last;

  sdsi_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata_raw)
  );

  assign mem_rdata  = rec_t'(mem_rdata_raw);
  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign idx_inc    = {1'b0, idx_q} + (IDX_W+1)'(1);
  assign drain_last = (CNT_W'(idx_inc) == count_q);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    new_d     = new_q;
    pend_d    = pend_q;
    first_d   = first_q;
    prev_d    = prev_q;
    mem_we    = 1'b0;
    mem_waddr = idx_inc[IDX_W-1:0];
    mem_wdata = new_q;
    mem_re    = 1'b0;
    mem_raddr = '0;
    out_load  = 1'b0;
    res_d     = '{status: pend_q, key: '0, name_high: '0, name_low: '0,
                  group_start: 1'b0, last: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_e'(in_i.cmd) == CMD_INSERT) begin
            if (in_i.rank_key == 8'd0 || in_i.rank_key[7]) begin
              pend_d  = ST_IGNORED;
              state_d = S_RESP;
            end else if (count_q == CNT_W'(CAPACITY)) begin
              pend_d  = ST_FULL;
              state_d = S_RESP;
            end else begin
              new_d = '{key: in_i.rank_key[KEY_W-1:0], name_high: in_i.name_high,
                        name_low: in_i.name_low};
              if (count_q == '0) begin
                idx_d   = '0;
                state_d = S_INS_PUT;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(count_q - CNT_W'(1));
                idx_d     = IDX_W'(count_q - CNT_W'(1));
                state_d   = S_INS_SCAN;
              end
            end
          end else begin
            if (count_q == '0) begin
              pend_d  = ST_EMPTY;
              state_d = S_RESP;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              idx_d     = '0;
              first_d   = 1'b1;
              state_d   = S_DRN_RD;
            end
          end
        end
      end

      S_INS_SCAN: begin
        mem_we = 1'b1;
        if (mem_rdata.key < new_q.key) begin
          // smaller key moves down one slot
          mem_wdata = mem_rdata;
          if (idx_q == '0) begin
            state_d = S_INS_PUT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_q - IDX_W'(1);
            idx_d     = idx_q - IDX_W'(1);
          end
        end else begin
          // lands after every entry with an equal or greater key
          mem_wdata = new_q;
          count_d   = count_q + CNT_W'(1);
          pend_d    = ST_INSERTED;
          state_d   = S_RESP;
        end
      end

      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = new_q;
        count_d   = count_q + CNT_W'(1);
        pend_d    = ST_INSERTED;
        state_d   = S_RESP;
      end

      S_DRN_RD: begin
        res_d = '{status: ST_ENTRY, key: mem_rdata.key, name_high: mem_rdata.name_high,
                  name_low: mem_rdata.name_low,
                  group_start: first_q || (mem_rdata.key != prev_q),
                  last: drain_last};
        if (out_free) begin
          out_load = 1'b1;
          prev_d   = mem_rdata.key;
          first_d  = 1'b0;
          if (drain_last) begin
            count_d = '0;
            state_d = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_inc[IDX_W-1:0];
            idx_d     = idx_inc[IDX_W-1:0];
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      first_q <= first_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    new_q  <= new_d;
    pend_q <= pend_d;
    prev_q <= prev_d;
    if (out_load) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_q.status;
  assign out_o.out_key       = out_q.key;
  assign out_o.out_name_high = out_q.name_high;
  assign out_o.out_name_low  = out_q.name_low;
  assign out_o.group_start   = out_q.group_start;
  assign out_o.last          = out_q.last;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_entry_key_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_ENTRY) |-> (out_q.key != '0))
    else $error("emitted entry with zero key");

  a_write_in_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_INS_SCAN || state_q == S_INS_PUT))
    else $error("ram write outside insert");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRN_RD && out_load && drain_last) |=> (count_q == '0))
    else $error("table not empty after drain");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !out_load)
    else $error("result overwritten while stalled");

endmodule
